// ===== rtl/core/caa_pkg.sv =====
package caa_pkg;

	localparam int unsigned CMD_W     = 2;
	localparam int unsigned CH_W      = 3;
	localparam int unsigned READING_W = 24;
	localparam int unsigned DAC_W     = 7;
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 24;

	localparam int unsigned NUM_CHANNELS_DEF = 8;

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PRESET = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DAC_STEP       = 2'd3;

	localparam logic [READING_W-1:0] RISE_THRESHOLD_RST = 24'd10000;
	localparam logic [READING_W-1:0] UPPER_LIMIT_RST    = 24'd16000000;
	localparam logic [READING_W-1:0] LOWER_LIMIT_RST    = 24'd1000000;
	localparam logic [DAC_W-1:0]     DAC_STEP_RST       = 7'h10;

	localparam logic [DAC_W-1:0]   DAC_MAX   = 7'h7F;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [CH_W-1:0]      channel;
		logic [READING_W-1:0] reading;
		logic                 maintenance;
		logic [DAC_W-1:0]     preset_value;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]    out_channel;
		logic               detected;
		logic [COUNT_W-1:0] event_count;
		logic [DAC_W-1:0]   dac_setting;
		logic               dac_changed;
	} out_item_t;

endpackage

// ===== rtl/core/caa_in_if.sv =====
interface caa_in_if;
	logic              valid;
	logic              ready;
	caa_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/caa_out_if.sv =====
interface caa_out_if;
	logic               valid;
	logic               ready;
	caa_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cap_channel_activity_and_autorange.sv =====
// Activity monitor and offset DAC auto-range for a set of capacitance channels.
// req carries one command per transaction: a sample (channel, reading,
// maintenance flag), a clear of all activity counters, or a DAC preset.
// rsp returns exactly one result per request: the channel echoed, the
// detection flag, the channel's counter and DAC setting after the command,
// and whether the DAC setting changed.
// The per-channel register file is read, updated and the result captured in the
// output register at the edge the request is accepted.
// Throughput is one transaction per cycle while rsp does not stall; the register
// file read-modify-write completes in that same cycle, so back-to-back samples of
// one channel see each other's updates.
// When rsp stalls, the output register holds its result and req.ready drops;
// it rises again in the cycle the result is taken. Reset clears counters, DAC
// settings and per-channel first-sample flags and loads the default configuration.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next edge;
// the user must make them only while the block is idle; the block does not check.
module cap_channel_activity_and_autorange #(
	parameter int unsigned NUM_CHANNELS = caa_pkg::NUM_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [caa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [caa_pkg::CFG_W-1:0]     cfg_data,
	caa_in_if.sink                        req,
	caa_out_if.source                     rsp
);

	// only channel codes below both the channel count and the field range are reachable
	localparam int unsigned CH_CODES = 1 << caa_pkg::CH_W;
	localparam int unsigned DEPTH    = (NUM_CHANNELS < CH_CODES) ? NUM_CHANNELS : CH_CODES;
	localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [caa_pkg::READING_W-1:0] rise_threshold_q;
	logic [caa_pkg::READING_W-1:0] upper_limit_q;
	logic [caa_pkg::READING_W-1:0] lower_limit_q;
	logic [caa_pkg::DAC_W-1:0]     dac_step_q;

	logic [caa_pkg::READING_W-1:0] prev_reading_q [DEPTH];
	logic [DEPTH-1:0]              prev_valid_q;
	logic [caa_pkg::COUNT_W-1:0]   count_q [DEPTH];
	logic [caa_pkg::DAC_W-1:0]     dac_q [DEPTH];

	logic               out_valid_q;
	caa_pkg::out_item_t out_data_q;

	logic                          accept;
	logic                          ch_ok;
	logic [IDX_W-1:0]              idx;
	logic [caa_pkg::READING_W:0]   rise_limit;
	logic [caa_pkg::DAC_W:0]       dac_up;
	logic [caa_pkg::DAC_W-1:0]     cur_dac;
	logic [caa_pkg::COUNT_W-1:0]   cur_count;
	logic [caa_pkg::DAC_W-1:0]     adj_dac;
	logic                          is_sample;
	logic                          is_preset;
	logic                          is_clear;
	logic                          detect;
	logic                          count_inc;
	logic [caa_pkg::COUNT_W-1:0]   new_count;
	logic [caa_pkg::DAC_W-1:0]     new_dac;
	caa_pkg::out_item_t            result;

	assign accept    = req.valid && req.ready;
	assign req.ready = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	assign ch_ok     = {1'b0, 7'(req.data.channel)} < 8'(NUM_CHANNELS);
	assign idx       = req.data.channel[IDX_W-1:0];
	assign cur_dac   = dac_q[idx];
	assign cur_count = count_q[idx];
	assign is_clear  = req.data.command == caa_pkg::CMD_CLEAR;
	assign is_sample = ch_ok && (req.data.command == caa_pkg::CMD_SAMPLE);
	assign is_preset = ch_ok && (req.data.command == caa_pkg::CMD_PRESET);

	// previous + threshold at one extra bit so it never wraps
	assign rise_limit = {1'b0, prev_reading_q[idx]} + {1'b0, rise_threshold_q};
	assign detect     = is_sample && prev_valid_q[idx]
	                    && ({1'b0, req.data.reading} > rise_limit);
	assign count_inc  = detect && !req.data.maintenance && (cur_count != caa_pkg::COUNT_MAX);
	assign dac_up     = {1'b0, cur_dac} + {1'b0, dac_step_q};

	always_comb begin
		adj_dac = cur_dac;
		if (req.data.reading > upper_limit_q) begin
			adj_dac = (dac_up > {1'b0, caa_pkg::DAC_MAX}) ? caa_pkg::DAC_MAX
			                                              : dac_up[caa_pkg::DAC_W-1:0];
		end else if (req.data.reading < lower_limit_q) begin
			adj_dac = (cur_dac >= dac_step_q) ? cur_dac - dac_step_q : '0;
		end
	end

	always_comb begin
		new_count = count_inc ? cur_count + 1'b1 : cur_count;
		if (is_sample) begin
			new_dac = adj_dac;
		end else if (is_preset) begin
			new_dac = req.data.preset_value;
		end else begin
			new_dac = cur_dac;
		end

		result.out_channel = req.data.channel;
		result.detected    = detect;
		result.event_count = '0;
		result.dac_setting = '0;
		result.dac_changed = 1'b0;
		if (ch_ok) begin
			result.dac_setting = new_dac;
			result.dac_changed = new_dac != cur_dac;
			if (!is_clear) begin
				result.event_count = new_count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_threshold_q <= caa_pkg::RISE_THRESHOLD_RST;
			upper_limit_q    <= caa_pkg::UPPER_LIMIT_RST;
			lower_limit_q    <= caa_pkg::LOWER_LIMIT_RST;
			dac_step_q       <= caa_pkg::DAC_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				caa_pkg::CFG_RISE_THRESHOLD: rise_threshold_q <= cfg_data;
				caa_pkg::CFG_UPPER_LIMIT:    upper_limit_q    <= cfg_data;
				caa_pkg::CFG_LOWER_LIMIT:    lower_limit_q    <= cfg_data;
				caa_pkg::CFG_DAC_STEP:       dac_step_q       <= cfg_data[caa_pkg::DAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				count_q[i] <= '0;
				dac_q[i]   <= '0;
			end
		end else if (accept) begin
			if (is_clear) begin
				for (int i = 0; i < DEPTH; i++) begin
					count_q[i] <= '0;
				end
			end
			if (is_sample) begin
				prev_valid_q[idx] <= 1'b1;
				count_q[idx]      <= new_count;
			end
			if (is_sample || is_preset) begin
				dac_q[idx] <= new_dac;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_sample) begin
			prev_reading_q[idx] <= req.data.reading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req.ready) begin
			out_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import caa_pkg::*;

	localparam int NUM_CH = NUM_CHANNELS_DEF;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAMP_SAMPLES = 200;
	localparam int PHASE_ITEMS = 245;
	localparam int MAX_REPORTED = 60;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	caa_in_if req_if ();
	caa_out_if rsp_if ();

	cap_channel_activity_and_autorange uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stimulus and scoreboard storage
	in_item_t cmd_queue[$];
	out_item_t awaited_reports[$];

	// shadow of the block's registers and per-channel state
	logic [READING_W-1:0] cfg_thr = RISE_THRESHOLD_RST;
	logic [READING_W-1:0] cfg_hi = UPPER_LIMIT_RST;
	logic [READING_W-1:0] cfg_lo = LOWER_LIMIT_RST;
	logic [DAC_W-1:0] cfg_step = DAC_STEP_RST;
	logic [READING_W-1:0] last_rd [NUM_CH];
	logic seen [NUM_CH];
	logic [COUNT_W-1:0] hits [NUM_CH];
	logic [DAC_W-1:0] dac_now [NUM_CH];

	// last reading queued per channel, used to aim samples at the threshold
	logic [READING_W-1:0] sent_rd [NUM_CH];

	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_arm = 1'b0;
	bit hold_used = 1'b0;
	int hold_left = 0;
	int fail_count = 0;
	int cycles = 0;
	int n_tx = 0;
	int n_det = 0;
	int n_dac_chg = 0;
	int n_sat = 0;

	initial begin
		for (int i = 0; i < NUM_CH; i++) begin
			last_rd[i] = '0;
			seen[i] = 1'b0;
			hits[i] = '0;
			dac_now[i] = '0;
			sent_rd[i] = '0;
		end
	end

	function automatic out_item_t predict_channel_update(in_item_t it);
		out_item_t r;
		logic [DAC_W-1:0] old_dac;
		logic [DAC_W-1:0] new_dac;
		logic [READING_W:0] rise_bar;
		r = '0;
		r.out_channel = it.channel;
		old_dac = dac_now[it.channel];
		case (it.command)
			CMD_CLEAR: begin
				for (int i = 0; i < NUM_CH; i++)
					hits[i] = '0;
				r.dac_setting = old_dac;
			end
			CMD_SAMPLE: begin
				if (seen[it.channel]) begin
					rise_bar = {1'b0, last_rd[it.channel]} + {1'b0, cfg_thr};
					if ({1'b0, it.reading} > rise_bar) begin
						r.detected = 1'b1;
						if (!it.maintenance && hits[it.channel] != COUNT_MAX)
							hits[it.channel] = hits[it.channel] + 1'b1;
					end
				end
				seen[it.channel] = 1'b1;
				last_rd[it.channel] = it.reading;
				new_dac = old_dac;
				if (it.reading > cfg_hi)
					new_dac = (DAC_MAX - old_dac >= cfg_step) ? old_dac + cfg_step : DAC_MAX;
				else if (it.reading < cfg_lo)
					new_dac = (old_dac >= cfg_step) ? old_dac - cfg_step : '0;
				r.dac_changed = new_dac != old_dac;
				dac_now[it.channel] = new_dac;
				r.event_count = hits[it.channel];
				r.dac_setting = new_dac;
			end
			CMD_PRESET: begin
				r.dac_changed = it.preset_value != old_dac;
				dac_now[it.channel] = it.preset_value;
				r.event_count = hits[it.channel];
				r.dac_setting = it.preset_value;
			end
			default: begin
				r.event_count = hits[it.channel];
				r.dac_setting = old_dac;
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			fail_count++;
			if (fail_count <= MAX_REPORTED)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, name, exp_v, act_v);
			if (fail_count == MAX_REPORTED)
				$display("further mismatches are counted but not listed");
		end
	endtask

	// driver: holds an offered transaction until it is taken
	always @(posedge clk) begin
		bit offer;
		if (arst_n && (!req_if.valid || req_if.ready)) begin
			offer = cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct;
			if (offer)
				req_if.data <= cmd_queue.pop_front();
			req_if.valid <= offer;
		end
	end

	// long receiver hold-off, run once when armed
	always @(posedge clk) begin
		if (hold_arm && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			rsp_if.ready <= hold_left == 0 && $urandom_range(99) >= stall_pct;
	end

	// monitor: retire the response first, then predict the newly taken request
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				n_tx++;
				if (rsp_if.data.detected === 1'b1)
					n_det++;
				if (rsp_if.data.dac_changed === 1'b1)
					n_dac_chg++;
				if (rsp_if.data.event_count === COUNT_MAX)
					n_sat++;
				if (awaited_reports.size() == 0) begin
					fail_count++;
					$display("%0t ns: unexpected result, expected none, actual %p",
						$time, rsp_if.data);
				end else begin
					want = awaited_reports.pop_front();
					compare_field("out_channel", 32'(want.out_channel),
						32'(rsp_if.data.out_channel));
					compare_field("detected", 32'(want.detected),
						32'(rsp_if.data.detected));
					compare_field("event_count", 32'(want.event_count),
						32'(rsp_if.data.event_count));
					compare_field("dac_setting", 32'(want.dac_setting),
						32'(rsp_if.data.dac_setting));
					compare_field("dac_changed", 32'(want.dac_changed),
						32'(rsp_if.data.dac_changed));
				end
			end
			if (req_if.valid && req_if.ready)
				awaited_reports.push_back(predict_channel_update(req_if.data));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still awaited",
				cycles, awaited_reports.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_cmd(logic [CMD_W-1:0] cmd, int ch, logic [READING_W-1:0] rd,
			bit maint, logic [DAC_W-1:0] pv);
		in_item_t it;
		it.command = cmd;
		it.channel = CH_W'(ch);
		it.reading = rd;
		it.maintenance = maint;
		it.preset_value = pv;
		if (cmd == CMD_SAMPLE)
			sent_rd[ch] = rd;
		cmd_queue.push_back(it);
	endtask

	// mostly readings near the rise threshold or the range limits
	function automatic logic [READING_W-1:0] pick_reading(int ch);
		logic [READING_W+1:0] v;
		logic [READING_W-1:0] d;
		int sel;
		sel = $urandom_range(99);
		if (sel < 35) begin
			v = 26'({2'b0, sent_rd[ch]} + cfg_thr
				+ ($urandom_range(1) ? $urandom_range(4095) : $urandom_range(3)) - 1);
		end else if (sel < 55) begin
			d = 24'($urandom_range(60000));
			v = sent_rd[ch] >= d ? {2'b0, sent_rd[ch] - d} : '0;
		end else if (sel < 65) begin
			v = 26'({2'b0, cfg_hi} + $urandom_range(2) - 1);
		end else if (sel < 75) begin
			v = 26'({2'b0, cfg_lo} + $urandom_range(2) - 1);
		end else if (sel < 82) begin
			v = $urandom_range(1) ? 26'hFFFFFF : 26'h0;
		end else begin
			v = 26'($urandom & 24'hFFFFFF);
		end
		if (v > 26'hFFFFFF)
			v = 26'($urandom & 24'hFFFFFF);
		return v[READING_W-1:0];
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_RISE_THRESHOLD: cfg_thr = val;
			CFG_UPPER_LIMIT: cfg_hi = val;
			CFG_LOWER_LIMIT: cfg_lo = val;
			default: cfg_step = val[DAC_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || req_if.valid || awaited_reports.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		int pick;
		int ch;
		logic [CMD_W-1:0] cmd;
		logic [READING_W-1:0] thr_v, hi_v, lo_v;
		logic [DAC_W-1:0] step_v, pv;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RISE_THRESHOLD;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items against the reset register values
		@(negedge clk);
		push_cmd(CMD_SAMPLE, 0, 24'd5000000, 1'b0, 7'd0);     // first sample only stores
		push_cmd(CMD_SAMPLE, 0, 24'd5010001, 1'b0, 7'd0);     // rise just over threshold
		push_cmd(CMD_SAMPLE, 0, 24'd5020001, 1'b0, 7'd0);     // rise equal to threshold
		push_cmd(CMD_SAMPLE, 0, 24'hFFFFFF, 1'b1, 7'h7F);     // maintenance: detect, no count
		push_cmd(CMD_SAMPLE, 1, 24'd0, 1'b0, 7'd0);           // low clamp at zero
		push_cmd(CMD_PRESET, 2, 24'd0, 1'b0, 7'd127);
		push_cmd(CMD_SAMPLE, 2, 24'hFFFFFF, 1'b0, 7'd0);      // high clamp, already at max
		push_cmd(CMD_PRESET, 2, 24'd0, 1'b0, 7'd127);         // preset to same value
		push_cmd(CMD_PRESET, 2, 24'd0, 1'b0, 7'd120);
		push_cmd(CMD_SAMPLE, 2, 24'd16000001, 1'b0, 7'd0);    // step larger than room
		push_cmd(CMD_PRESET, 3, 24'd0, 1'b0, 7'd5);
		push_cmd(CMD_SAMPLE, 3, 24'd999999, 1'b0, 7'd0);
		push_cmd(CMD_SAMPLE, 3, 24'd16000000, 1'b0, 7'd0);    // on the limits: no change
		push_cmd(CMD_SAMPLE, 3, 24'd1000000, 1'b0, 7'd0);
		push_cmd(CMD_SAMPLE, 4, 24'hFFFFF0, 1'b0, 7'd0);
		push_cmd(CMD_SAMPLE, 4, 24'hFFFFFF, 1'b0, 7'd0);      // previous plus threshold past 24 bits
		push_cmd(CMD_SPARE, 0, 24'hAAAAAA, 1'b1, 7'd55);
		push_cmd(CMD_CLEAR, 0, 24'h555555, 1'b0, 7'd42);
		push_cmd(CMD_SAMPLE, 0, 24'd0, 1'b0, 7'd0);
		push_cmd(CMD_PRESET, 7, 24'd0, 1'b0, 7'd0);
		push_cmd(CMD_SAMPLE, 7, 24'h555555, 1'b1, 7'h7F);
		push_cmd(CMD_SPARE, 5, 24'd0, 1'b0, 7'd0);
		push_cmd(CMD_CLEAR, 7, 24'hFFFFFF, 1'b1, 7'h7F);
		wait_idle();

		// count one channel up on every sample after the first with a zero threshold
		write_reg(CFG_RISE_THRESHOLD, 24'd0);
		@(negedge clk);
		for (int k = 0; k < RAMP_SAMPLES; k++)
			push_cmd(CMD_SAMPLE, 5, 24'(k), 1'b0, 7'($urandom));
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			thr_v = 24'($urandom_range(200000));
			hi_v = 24'($urandom_range(24'hFFFFFF, 12000000));
			lo_v = 24'($urandom_range(4000000));
			step_v = 7'($urandom_range(127, 1));
			if (ph == 1) begin
				thr_v = '0;
				hi_v = 24'hFFFFFF;
				lo_v = '0;
				step_v = 7'd127;
			end else if (ph == 3) begin
				thr_v = 24'hFFFFFF;
				hi_v = '0;
				lo_v = 24'hFFFFFF;
				step_v = '0;
			end else if (ph == 4) begin
				step_v = 7'd1;
			end
			write_reg(CFG_RISE_THRESHOLD, thr_v);
			write_reg(CFG_UPPER_LIMIT, hi_v);
			write_reg(CFG_LOWER_LIMIT, lo_v);
			write_reg(CFG_DAC_STEP, 24'($urandom & 24'hFFFF80) | {17'd0, step_v});

			@(negedge clk);
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 61; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 61; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			if (ph == 2)
				hold_arm = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(99);
				ch = $urandom_range(NUM_CH - 1);
				pv = $urandom_range(3) == 0 ? ($urandom_range(1) ? DAC_MAX : 7'd0)
					: 7'($urandom);
				if (pick < 5)
					cmd = CMD_CLEAR;
				else if (pick < 11)
					cmd = CMD_PRESET;
				else if (pick < 15)
					cmd = CMD_SPARE;
				else
					cmd = CMD_SAMPLE;
				push_cmd(cmd, ch, cmd == CMD_SAMPLE ? pick_reading(ch) : 24'($urandom),
					$urandom_range(99) < 20, pv);
			end
			wait_idle();
		end

		$display("%0d transactions checked over 8 register settings and 4 idle patterns",
			n_tx);
		$display("%0d detections, %0d DAC changes, %0d results at full count",
			n_det, n_dac_chg, n_sat);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== cap_channel_activity_and_autorange.f =====
rtl/core/caa_pkg.sv
rtl/core/caa_in_if.sv
rtl/core/caa_out_if.sv
rtl/core/cap_channel_activity_and_autorange.sv
verif/tb_top.sv
